[rtl/core/tcf_pkg.sv]
// Shared types, constants and the arctangent table for the tilt complementary filter.
`default_nettype none

package tcf_pkg;

    // Default number of CORDIC steps and the length of the arctangent table
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int ATAN_IDX_W       = 5;

    // CORDIC datapath width: operands scaled by 2^14 plus gain growth, Q30 angle
    localparam int CORD_W = 34;
    // Tilt angle in Q2.13 with headroom for the CORDIC overshoot
    localparam int TILT_W = 17;

    localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Register indexes on the configuration port
    localparam logic REG_BLEND_WEIGHT = 1'b0;
    localparam logic REG_TIME_STEP    = 1'b1;

    // Register reset values
    localparam logic [15:0] BLEND_WEIGHT_RST = 16'd65372;
    localparam logic [15:0] TIME_STEP_RST    = 16'd262;

    typedef enum logic [1:0] {
        CORD_IDLE,
        CORD_RUN,
        CORD_DONE
    } cord_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PITCH_GO,
        ST_PITCH_WAIT,
        ST_ROLL_GO,
        ST_ROLL_WAIT,
        ST_GYRO,
        ST_DIFF,
        ST_MUL_W,
        ST_MUL_C,
        ST_SUM,
        ST_OUT
    } seq_state_t;

    // Request to the CORDIC unit: atan2(y, x)
    typedef struct packed {
        logic               start;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } cord_req_t;

    // Result from the CORDIC unit, angle valid while done is high
    typedef struct packed {
        logic                     done;
        logic signed [TILT_W-1:0] angle;
    } cord_res_t;

    // Truncated Q30 value of atan(2^-idx)
    function automatic logic signed [CORD_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CORD_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 34'sh03243F6A8;
                5'd1:    val = 34'sh01DAC6705;
                5'd2:    val = 34'sh00FADBAFC;
                5'd3:    val = 34'sh007F56EA6;
                5'd4:    val = 34'sh003FEAB76;
                5'd5:    val = 34'sh001FFD55B;
                5'd6:    val = 34'sh000FFFAAA;
                5'd7:    val = 34'sh0007FFF55;
                5'd8:    val = 34'sh0003FFFEA;
                5'd9:    val = 34'sh0001FFFFD;
                5'd10:   val = 34'sh0000FFFFF;
                5'd11:   val = 34'sh00007FFFF;
                5'd12:   val = 34'sh00003FFFF;
                5'd13:   val = 34'sh00001FFFF;
                5'd14:   val = 34'sh00000FFFF;
                5'd15:   val = 34'sh000007FFF;
                5'd16:   val = 34'sh000003FFF;
                5'd17:   val = 34'sh000001FFF;
                5'd18:   val = 34'sh000000FFF;
                5'd19:   val = 34'sh0000007FF;
                5'd20:   val = 34'sh0000003FF;
                5'd21:   val = 34'sh0000001FF;
                5'd22:   val = 34'sh0000000FF;
                5'd23:   val = 34'sh00000007F;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/tcf_cordic.sv]
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives atan2(y, x) in Q2.13.
`default_nettype none

module tcf_cordic
    import tcf_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  wire       clk,
    input  wire       rst_n,
    input  cord_req_t req,
    output cord_res_t res
);

    localparam int STEPS_EFF = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
    localparam int STEP_W    = $clog2(STEPS_EFF);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_EFF - 1);

    cord_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [CORD_W-1:0] z_reg, z_next;
    logic zero_reg, zero_next;

    logic signed [CORD_W-1:0] x_ld, y_ld;
    logic signed [CORD_W-1:0] dx, dy, atan_val;
    logic signed [CORD_W-1:0] angle_full;

    // Scale the operands by 2^14
    assign x_ld = CORD_W'($signed(req.x)) <<< 14;
    assign y_ld = CORD_W'($signed(req.y)) <<< 14;

    // Shared shifter and table lookup for the current step
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = atan_q30(ATAN_IDX_W'(step_reg));

    // Round the Q30 angle to Q2.13
    assign angle_full = (z_reg + CORD_W'(65536)) >>> 17;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CORD_IDLE:
            begin
                if (req.start)
                    state_next = CORD_RUN;
            end
            CORD_RUN:
            begin
                if (step_reg == LAST_STEP)
                    state_next = CORD_DONE;
            end
            CORD_DONE:
            begin
                state_next = CORD_IDLE;
            end
            default:
            begin
                state_next = CORD_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        res.done  = (state_reg == CORD_DONE);
        res.angle = zero_reg ? '0 : TILT_W'(angle_full);
    end

    // Load, pre-rotate and iterate
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        step_next = '0;
        if (state_reg == CORD_IDLE && req.start)
        begin
            zero_next = (req.x == '0) && (req.y == '0);
            if (!x_ld[CORD_W-1])
            begin
                x_next = x_ld;
                y_next = y_ld;
                z_next = '0;
            end
            else if (!y_ld[CORD_W-1])
            begin
                // Quarter turn clockwise
                x_next = y_ld;
                y_next = -x_ld;
                z_next = HALF_PI_Q30;
            end
            else
            begin
                // Quarter turn anticlockwise
                x_next = -y_ld;
                y_next = x_ld;
                z_next = -HALF_PI_Q30;
            end
        end
        else if (state_reg == CORD_RUN)
        begin
            step_next = step_reg + 1'b1;
            if (!y_reg[CORD_W-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORD_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

endmodule

`default_nettype wire

[rtl/core/tilt_complementary_filter.sv]
// Top level of the tilt complementary filter: sequencer, shared multiplier and register port.
`default_nettype none

// Pitch and roll complementary filter. Each sample transaction runs two
// atan2 evaluations on one iterative CORDIC unit (one micro-rotation per
// cycle) and then two blends on one shared 21x18 multiplier. The result is
// offered once both atan2 evaluations, both blends and the load of the
// output register are done. sample_stall is high from acceptance until the
// result is loaded into the output register; a result waiting there does
// not stop the next sample from being accepted, but that sample is held
// after its blends until the waiting result is taken. The estimates
// saturate to the Q2.13 range and both reset to zero. Registers:
// blend_weight at byte address 0, time_step at byte address 4; write them
// only while no sample is in flight.
module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire               clk,
    input  wire               rst_n,
    // Configuration port
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [2:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Sample channel
    input  wire               sample_valid,
    output logic              sample_stall,
    input  wire signed [15:0] accel_x,
    input  wire signed [15:0] accel_y,
    input  wire signed [15:0] accel_z,
    input  wire signed [15:0] rate_x,
    input  wire signed [15:0] rate_y,
    // Result channel
    output logic              result_valid,
    input  wire               result_stall,
    output logic signed [15:0] pitch_out,
    output logic signed [15:0] roll_out
);

    seq_state_t state_reg, state_next;
    logic axis_reg, axis_next;

    logic [15:0] weight_reg, weight_next;
    logic [15:0] dt_reg, dt_next;
    logic signed [15:0] pitch_est_reg, pitch_est_next;
    logic signed [15:0] roll_est_reg, roll_est_next;
    logic out_valid_reg, out_valid_next;

    logic signed [15:0] ax_reg, ax_next;
    logic signed [15:0] ay_reg, ay_next;
    logic signed [15:0] az_reg, az_next;
    logic signed [15:0] rx_reg, rx_next;
    logic signed [15:0] ry_reg, ry_next;
    logic signed [TILT_W-1:0] tilt_p_reg, tilt_p_next;
    logic signed [TILT_W-1:0] tilt_r_reg, tilt_r_next;
    logic signed [38:0] prod_reg, prod_next;
    logic signed [38:0] acc_reg, acc_next;
    logic signed [20:0] diff_reg, diff_next;
    logic signed [15:0] pitch_out_reg, pitch_out_next;
    logic signed [15:0] roll_out_reg, roll_out_next;

    cord_req_t cord_req;
    cord_res_t cord_res;

    logic cfg_write;
    logic accept;
    logic out_free;

    logic signed [15:0] rate_sel, prev_sel;
    logic signed [TILT_W-1:0] tilt_sel;
    logic signed [20:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [38:0] mul_p;
    logic signed [38:0] gyro_full, diff_full;
    logic signed [39:0] sum_full, sum_sh;
    logic signed [15:0] blend_sat;

    tcf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cord_req),
        .res   (cord_res)
    );

    assign cfg_write = psel && penable && pwrite && pready;
    assign accept    = sample_valid && !sample_stall;
    assign out_free  = !out_valid_reg || !result_stall;

    // Register read-back
    always_comb
    begin
        pready = 1'b1;
        case (paddr[2])
            REG_BLEND_WEIGHT: prdata = {16'd0, weight_reg};
            REG_TIME_STEP:    prdata = {16'd0, dt_reg};
            default:          prdata = '0;
        endcase
    end

    // Select the axis being blended
    assign rate_sel = axis_reg ? rx_reg : ry_reg;
    assign prev_sel = axis_reg ? roll_est_reg : pitch_est_reg;
    assign tilt_sel = axis_reg ? tilt_r_reg : tilt_p_reg;

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_GYRO:
            begin
                mul_a = 21'(rate_sel);
                mul_b = $signed({2'b00, dt_reg});
            end
            ST_MUL_W:
            begin
                mul_a = diff_reg;
                mul_b = $signed({2'b00, weight_reg});
            end
            default:
            begin
                mul_a = 21'(tilt_sel);
                mul_b = $signed(18'h10000 - {2'b00, weight_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round the gyro term to Q2.13 and take it from the previous estimate
    assign gyro_full = (prod_reg + 39'sd4096) >>> 13;
    assign diff_full = 39'(prev_sel) - gyro_full;

    // Add both blend products, round and saturate
    assign sum_full = 40'(acc_reg) + 40'(prod_reg) + 40'sd32768;
    assign sum_sh   = sum_full >>> 16;

    always_comb
    begin
        if (sum_sh > 40'sd32767)
            blend_sat = 16'sh7FFF;
        else if (sum_sh < -40'sd32768)
            blend_sat = 16'sh8000;
        else
            blend_sat = 16'(sum_sh);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_PITCH_GO;
            end
            ST_PITCH_GO:   state_next = ST_PITCH_WAIT;
            ST_PITCH_WAIT:
            begin
                if (cord_res.done)
                    state_next = ST_ROLL_GO;
            end
            ST_ROLL_GO:    state_next = ST_ROLL_WAIT;
            ST_ROLL_WAIT:
            begin
                if (cord_res.done)
                    state_next = ST_GYRO;
            end
            ST_GYRO:       state_next = ST_DIFF;
            ST_DIFF:       state_next = ST_MUL_W;
            ST_MUL_W:      state_next = ST_MUL_C;
            ST_MUL_C:      state_next = ST_SUM;
            ST_SUM:        state_next = axis_reg ? ST_OUT : ST_GYRO;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        sample_stall   = (state_reg != ST_IDLE);
        cord_req.start = (state_reg == ST_PITCH_GO) || (state_reg == ST_ROLL_GO);
        cord_req.y     = (state_reg == ST_ROLL_GO) ? ay_reg : ax_reg;
        cord_req.x     = az_reg;
        result_valid   = out_valid_reg;
        pitch_out      = pitch_out_reg;
        roll_out       = roll_out_reg;
    end

    // Datapath and register updates
    always_comb
    begin
        weight_next    = weight_reg;
        dt_next        = dt_reg;
        axis_next      = axis_reg;
        pitch_est_next = pitch_est_reg;
        roll_est_next  = roll_est_reg;
        out_valid_next = out_valid_reg && result_stall;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        tilt_p_next    = tilt_p_reg;
        tilt_r_next    = tilt_r_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        diff_next      = diff_reg;
        pitch_out_next = pitch_out_reg;
        roll_out_next  = roll_out_reg;

        // Register writes
        if (cfg_write)
        begin
            case (paddr[2])
                REG_BLEND_WEIGHT: weight_next = pwdata[15:0];
                REG_TIME_STEP:    dt_next     = pwdata[15:0];
                default:          weight_next = weight_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ax_next   = accel_x;
                    ay_next   = accel_y;
                    az_next   = accel_z;
                    rx_next   = rate_x;
                    ry_next   = rate_y;
                    axis_next = 1'b0;
                end
            end
            ST_PITCH_WAIT:
            begin
                if (cord_res.done)
                    tilt_p_next = cord_res.angle;
            end
            ST_ROLL_WAIT:
            begin
                if (cord_res.done)
                    tilt_r_next = -cord_res.angle;
            end
            ST_GYRO:
            begin
                prod_next = mul_p;
            end
            ST_DIFF:
            begin
                diff_next = 21'(diff_full);
            end
            ST_MUL_W:
            begin
                prod_next = mul_p;
            end
            ST_MUL_C:
            begin
                acc_next  = prod_reg;
                prod_next = mul_p;
            end
            ST_SUM:
            begin
                if (axis_reg)
                    roll_est_next = blend_sat;
                else
                    pitch_est_next = blend_sat;
                axis_next = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    pitch_out_next = pitch_est_reg;
                    roll_out_next  = roll_est_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                axis_next = axis_reg;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            weight_reg    <= BLEND_WEIGHT_RST;
            dt_reg        <= TIME_STEP_RST;
            pitch_est_reg <= '0;
            roll_est_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            weight_reg    <= weight_next;
            dt_reg        <= dt_next;
            pitch_est_reg <= pitch_est_next;
            roll_est_reg  <= roll_est_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        tilt_p_reg    <= tilt_p_next;
        tilt_r_reg    <= tilt_r_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        diff_reg      <= diff_next;
        pitch_out_reg <= pitch_out_next;
        roll_out_reg  <= roll_out_next;
    end

endmodule

`default_nettype wire
